FILE: sv/ccsr_pkg.sv
`default_nettype none
package ccsr_pkg;

  // host command codes
  localparam logic [7:0] MSG_SET_PARAMS   = 8'h61;
  localparam logic [7:0] MSG_POWER_ON     = 8'h62;
  localparam logic [7:0] MSG_POWER_OFF    = 8'h63;
  localparam logic [7:0] MSG_SLOT_STATUS  = 8'h65;
  localparam logic [7:0] MSG_SECURE       = 8'h69;
  localparam logic [7:0] MSG_ESCAPE       = 8'h6B;
  localparam logic [7:0] MSG_GET_PARAMS   = 8'h6C;
  localparam logic [7:0] MSG_RESET_PARAMS = 8'h6D;
  localparam logic [7:0] MSG_XFR_BLOCK    = 8'h6F;

  // reply codes
  localparam logic [7:0] RSP_DATA_BLOCK   = 8'h80;
  localparam logic [7:0] RSP_SLOT_STATUS  = 8'h81;
  localparam logic [7:0] RSP_PARAMETERS   = 8'h82;
  localparam logic [7:0] RSP_ESCAPE       = 8'h83;

  // error codes
  localparam logic [7:0] ERR_NONE         = 8'h00;
  localparam logic [7:0] ERR_UNSUPPORTED  = 8'h00;
  localparam logic [7:0] ERR_LENGTH       = 8'h01;
  localparam logic [7:0] ERR_SLOT         = 8'h05;
  localparam logic [7:0] ERR_RFU3         = 8'h07;
  localparam logic [7:0] ERR_POWER        = 8'h07;
  localparam logic [7:0] ERR_RFU2         = 8'h08;
  localparam logic [7:0] ERR_BUSY         = 8'hE0;
  localparam logic [7:0] ERR_OK           = 8'h81;

  // slot status byte
  localparam logic [7:0] STATUS_RESET     = 8'h01;
  localparam logic [7:0] STATUS_FAILED    = 8'h40;
  localparam logic [1:0] CARD_ACTIVE      = 2'd0;
  localparam logic [1:0] CARD_INACTIVE    = 2'd1;
  localparam logic [7:0] SPEC_T1          = 8'h01;
  localparam logic [15:0] DISCARD_SW_RESET = 16'h6400;

  // byte positions
  localparam int HDR_BYTES = 10;
  localparam logic [4:0] IDX_TYPE   = 5'd0;
  localparam logic [4:0] IDX_LEN0   = 5'd1;
  localparam logic [4:0] IDX_SLOT   = 5'd5;
  localparam logic [4:0] IDX_SEQ    = 5'd6;
  localparam logic [4:0] IDX_STATUS = 5'd7;
  localparam logic [4:0] IDX_ERROR  = 5'd8;
  localparam logic [4:0] IDX_SPEC   = 5'd9;

  localparam logic [4:0] LEN_NONE    = 5'd0;
  localparam logic [4:0] LEN_DISCARD = 5'd2;
  localparam logic [4:0] LEN_PARAMS  = 5'd7;
  localparam logic [4:0] LEN_ATR     = 5'd17;

  typedef enum logic [1:0] {
    DATA_NONE,
    DATA_ATR,
    DATA_PARAMS,
    DATA_DISCARD
  } data_sel_e;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic [7:0]  message_type;
    logic [7:0]  slot;
    logic [7:0]  sequence_req;
    logic [31:0] payload_length;
    logic [7:0]  specific_zero;
    logic [7:0]  specific_one;
    logic [7:0]  specific_two;
    logic        data_discarded;
    logic        session_busy;
  } in_word_t;

  typedef struct packed {
    logic [7:0] response_byte;
    logic       last_byte;
    logic       forward_apdu;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic [4:0] idx;
    logic       last;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       forward;
    logic [4:0] last_idx;
  } dp_status_t;

  // answer to reset
  function automatic logic [7:0] atr_byte(input logic [4:0] i);
    logic [7:0] b;
    case (i)
      5'd0:  b = 8'h3B;
      5'd1:  b = 8'hF7;
      5'd2:  b = 8'h11;
      5'd3:  b = 8'h00;
      5'd4:  b = 8'h00;
      5'd5:  b = 8'h81;
      5'd6:  b = 8'h31;
      5'd7:  b = 8'hFE;
      5'd8:  b = 8'h65;
      5'd9:  b = 8'h43;
      5'd10: b = 8'h61;
      5'd11: b = 8'h6E;
      5'd12: b = 8'h6F;
      5'd13: b = 8'h6B;
      5'd14: b = 8'h65;
      5'd15: b = 8'h79;
      5'd16: b = 8'h99;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // protocol T=1 parameters
  function automatic logic [7:0] params_byte(input logic [2:0] i);
    logic [7:0] b;
    case (i)
      3'd0: b = 8'h11;
      3'd1: b = 8'h10;
      3'd2: b = 8'h00;
      3'd3: b = 8'h15;
      3'd4: b = 8'h00;
      3'd5: b = 8'hFE;
      3'd6: b = 8'h00;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

FILE: sv/ccsr_ctrl.sv
`default_nettype none
module ccsr_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire ccsr_pkg::dp_status_t status_i,
  output ccsr_pkg::ctrl_cmd_t       cmd_o
);

  ccsr_pkg::ctrl_state_e state_q, state_d;
  logic [4:0] idx_q, idx_d;
  logic       last;

  // state and byte counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ccsr_pkg::ST_IDLE;
      idx_q   <= 5'd0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  assign last = status_i.forward || (idx_q == status_i.last_idx);

  // next state and handshake
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o.load  = 1'b0;
    cmd_o.idx   = idx_q;
    cmd_o.last  = last;
    case (state_q)
      ccsr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          idx_d      = 5'd0;
          state_d    = ccsr_pkg::ST_EMIT;
        end
      end
      ccsr_pkg::ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (last) begin
            state_d = ccsr_pkg::ST_IDLE;
          end else begin
            idx_d = idx_q + 5'd1;
          end
        end
      end
      default: begin
        state_d = ccsr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/ccsr_datapath.sv
`default_nettype none
module ccsr_datapath #(
  parameter int SLOT_COUNT = 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ccsr_pkg::in_word_t   in_word_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [15:0]          cfg_data_i,
  input  wire ccsr_pkg::ctrl_cmd_t  cmd_i,
  output ccsr_pkg::dp_status_t      status_o,
  output ccsr_pkg::out_word_t       out_word_o
);

  logic [7:0]  status_q, status_d;
  logic [15:0] dsw_q;
  logic [7:0]  rtype_q, rtype_d;
  logic [4:0]  len_q, len_d;
  logic [7:0]  slot_q, seq_q;
  logic [7:0]  err_q, err_d;
  logic [7:0]  spec_q, spec_d;
  logic        fwd_q, fwd_d;
  ccsr_pkg::data_sel_e sel_q, sel_d;

  logic [1:0] card;
  logic       slot_bad, len_bad, rfu2_bad, rfu3_bad;
  logic [7:0] chk2_err, chk3_err;
  logic [7:0] failed_st, card_st;
  logic [4:0] data_off;
  logic [7:0] byte_val;

  // header checks
  assign card      = status_q[1:0];
  assign slot_bad  = in_word_i.slot >= 8'(SLOT_COUNT);
  assign len_bad   = |in_word_i.payload_length;
  assign rfu2_bad  = (|in_word_i.specific_one) || (|in_word_i.specific_two);
  assign rfu3_bad  = rfu2_bad || (|in_word_i.specific_zero);
  assign chk2_err  = slot_bad ? ccsr_pkg::ERR_SLOT :
                     len_bad  ? ccsr_pkg::ERR_LENGTH :
                     rfu2_bad ? ccsr_pkg::ERR_RFU2 : ccsr_pkg::ERR_NONE;
  assign chk3_err  = slot_bad ? ccsr_pkg::ERR_SLOT :
                     len_bad  ? ccsr_pkg::ERR_LENGTH :
                     rfu3_bad ? ccsr_pkg::ERR_RFU3 : ccsr_pkg::ERR_NONE;
  assign failed_st = ccsr_pkg::STATUS_FAILED | {6'd0, card};
  assign card_st   = {6'd0, card};

  // command decode
  always_comb begin
    status_d = status_q;
    rtype_d  = ccsr_pkg::RSP_SLOT_STATUS;
    len_d    = ccsr_pkg::LEN_NONE;
    err_d    = ccsr_pkg::ERR_UNSUPPORTED;
    spec_d   = 8'h00;
    fwd_d    = 1'b0;
    sel_d    = ccsr_pkg::DATA_NONE;
    case (in_word_i.message_type)
      ccsr_pkg::MSG_POWER_ON: begin
        rtype_d = ccsr_pkg::RSP_DATA_BLOCK;
        if (chk2_err != ccsr_pkg::ERR_NONE) begin
          err_d    = chk2_err;
          status_d = failed_st;
        end else if (|in_word_i.specific_zero) begin
          err_d    = ccsr_pkg::ERR_POWER;
          status_d = failed_st;
        end else if (in_word_i.session_busy) begin
          err_d    = ccsr_pkg::ERR_BUSY;
          status_d = failed_st;
        end else begin
          err_d    = ccsr_pkg::ERR_OK;
          status_d = {6'd0, ccsr_pkg::CARD_ACTIVE};
          len_d    = ccsr_pkg::LEN_ATR;
          sel_d    = ccsr_pkg::DATA_ATR;
        end
      end
      ccsr_pkg::MSG_POWER_OFF: begin
        rtype_d = ccsr_pkg::RSP_SLOT_STATUS;
        if (chk3_err != ccsr_pkg::ERR_NONE) begin
          err_d    = chk3_err;
          status_d = failed_st;
        end else if (in_word_i.session_busy) begin
          err_d    = ccsr_pkg::ERR_BUSY;
          status_d = failed_st;
        end else begin
          err_d    = ccsr_pkg::ERR_OK;
          status_d = {6'd0, ccsr_pkg::CARD_INACTIVE};
        end
      end
      ccsr_pkg::MSG_SLOT_STATUS: begin
        rtype_d = ccsr_pkg::RSP_SLOT_STATUS;
        if (chk3_err != ccsr_pkg::ERR_NONE) begin
          err_d    = chk3_err;
          status_d = failed_st;
        end else begin
          err_d    = ccsr_pkg::ERR_OK;
          status_d = card_st;
        end
      end
      ccsr_pkg::MSG_GET_PARAMS: begin
        rtype_d = ccsr_pkg::RSP_PARAMETERS;
        spec_d  = ccsr_pkg::SPEC_T1;
        if (chk3_err != ccsr_pkg::ERR_NONE) begin
          err_d    = chk3_err;
          status_d = failed_st;
        end else begin
          err_d    = ccsr_pkg::ERR_OK;
          status_d = card_st;
          len_d    = ccsr_pkg::LEN_PARAMS;
          sel_d    = ccsr_pkg::DATA_PARAMS;
        end
      end
      ccsr_pkg::MSG_XFR_BLOCK: begin
        if (in_word_i.data_discarded) begin
          rtype_d = ccsr_pkg::RSP_DATA_BLOCK;
          err_d   = ccsr_pkg::ERR_OK;
          len_d   = ccsr_pkg::LEN_DISCARD;
          sel_d   = ccsr_pkg::DATA_DISCARD;
        end else begin
          fwd_d    = 1'b1;
          status_d = slot_bad ? failed_st : {6'd0, ccsr_pkg::CARD_ACTIVE};
        end
      end
      ccsr_pkg::MSG_SET_PARAMS, ccsr_pkg::MSG_RESET_PARAMS: begin
        rtype_d  = ccsr_pkg::RSP_PARAMETERS;
        spec_d   = ccsr_pkg::SPEC_T1;
        status_d = failed_st;
      end
      ccsr_pkg::MSG_ESCAPE: begin
        rtype_d  = ccsr_pkg::RSP_ESCAPE;
        status_d = failed_st;
      end
      ccsr_pkg::MSG_SECURE: begin
        rtype_d  = ccsr_pkg::RSP_DATA_BLOCK;
        status_d = failed_st;
      end
      default: begin
        rtype_d  = ccsr_pkg::RSP_SLOT_STATUS;
        status_d = failed_st;
      end
    endcase
  end

  // slot status, discard word, forward flag and data length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= ccsr_pkg::STATUS_RESET;
      dsw_q    <= ccsr_pkg::DISCARD_SW_RESET;
      fwd_q    <= 1'b0;
      len_q    <= ccsr_pkg::LEN_NONE;
    end else begin
      if (cmd_i.load) begin
        status_q <= status_d;
        fwd_q    <= fwd_d;
        len_q    <= len_d;
      end
      if (cfg_we_i) begin
        dsw_q <= cfg_data_i;
      end
    end
  end

  // response header fields and data select
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rtype_q <= rtype_d;
      slot_q  <= in_word_i.slot;
      seq_q   <= in_word_i.sequence_req;
      err_q   <= err_d;
      spec_q  <= spec_d;
      sel_q   <= sel_d;
    end
  end

  assign status_o.forward  = fwd_q;
  assign status_o.last_idx = 5'(ccsr_pkg::HDR_BYTES - 1) + len_q;

  // byte select by position
  assign data_off = cmd_i.idx - 5'(ccsr_pkg::HDR_BYTES);
  always_comb begin
    case (cmd_i.idx)
      ccsr_pkg::IDX_TYPE:   byte_val = rtype_q;
      ccsr_pkg::IDX_LEN0:   byte_val = {3'd0, len_q};
      ccsr_pkg::IDX_SLOT:   byte_val = slot_q;
      ccsr_pkg::IDX_SEQ:    byte_val = seq_q;
      ccsr_pkg::IDX_STATUS: byte_val = status_q;
      ccsr_pkg::IDX_ERROR:  byte_val = err_q;
      ccsr_pkg::IDX_SPEC:   byte_val = spec_q;
      5'd2, 5'd3, 5'd4:     byte_val = 8'h00;
      default: begin
        case (sel_q)
          ccsr_pkg::DATA_ATR:     byte_val = ccsr_pkg::atr_byte(data_off);
          ccsr_pkg::DATA_PARAMS:  byte_val = ccsr_pkg::params_byte(data_off[2:0]);
          ccsr_pkg::DATA_DISCARD: byte_val = data_off[0] ? dsw_q[7:0] : dsw_q[15:8];
          default:                byte_val = 8'h00;
        endcase
      end
    endcase
  end

  // output word
  assign out_word_o.response_byte = fwd_q ? 8'h00 : byte_val;
  assign out_word_o.last_byte     = cmd_i.last && !fwd_q;
  assign out_word_o.forward_apdu  = fwd_q;

endmodule
`default_nettype wire

FILE: sv/ccid_slot_command_responder.sv
// ccid slot command responder: one command header in, its response out one byte a cycle
//   while out_ready_i is high; first word is valid the cycle after the command is taken
// a response is 10 header bytes plus data length (0 to 17) bytes, one word if forwarded;
//   the byte counter in the controller walks it, and a new command waits until it is done
// reset: asynchronous, active low; slot status returns to 0x01, discard status word to 0x6400
`default_nettype none
module ccid_slot_command_responder #(
  parameter int SLOT_COUNT = 1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire ccsr_pkg::in_word_t  in_word_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output ccsr_pkg::out_word_t      out_word_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [15:0]         cfg_data_i
);

  ccsr_pkg::ctrl_cmd_t  cmd;
  ccsr_pkg::dp_status_t status;

  // configuration is always taken
  assign cfg_ready_o = 1'b1;

  // controller
  ccsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath
  ccsr_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_word_o (out_word_o)
  );

endmodule
`default_nettype wire
